@@ rtl/core/psee_pkg.sv @@
// Package for the gamepad edge-event encoder: payload types, state codes and constants.
`default_nettype none
package psee_pkg;

    localparam int NumChannels = 25;
    localparam int ChW         = 5;
    localparam int CmpSteps    = 10;
    localparam int StepW       = 4;
    localparam int AxisW       = 16;
    localparam int CmpW        = AxisW + 1;
    localparam int TrigThrW    = 8;
    localparam int StickThrW   = 15;
    localparam int CfgDataW    = 15;
    localparam int CfgIndexW   = 1;

    localparam logic [TrigThrW-1:0]  TrigThrReset  = 8'd64;
    localparam logic [StickThrW-1:0] StickThrReset = 15'd16384;

    // Register indexes on the configuration port
    localparam logic [CfgIndexW-1:0] RegTrigThr  = 1'd0;
    localparam logic [CfgIndexW-1:0] RegStickThr = 1'd1;

    // Channel numbers of the analog channels
    localparam logic [ChW-1:0] ChLt       = 5'd15;
    localparam logic [ChW-1:0] ChRt       = 5'd16;
    localparam logic [ChW-1:0] ChLsUp     = 5'd17;
    localparam logic [ChW-1:0] ChLsDown   = 5'd18;
    localparam logic [ChW-1:0] ChLsLeft   = 5'd19;
    localparam logic [ChW-1:0] ChLsRight  = 5'd20;
    localparam logic [ChW-1:0] ChRsUp     = 5'd21;
    localparam logic [ChW-1:0] ChRsDown   = 5'd22;
    localparam logic [ChW-1:0] ChRsLeft   = 5'd23;
    localparam logic [ChW-1:0] ChRsRight  = 5'd24;
    localparam logic [ChW-1:0] ChLastIdx  = 5'd24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic        [31:0] time_ms;
        logic        [15:0] buttons;
        logic        [7:0]  trig_l;
        logic        [7:0]  trig_r;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
    } in_item_t;

    typedef struct packed {
        logic [31:0]    event_time_ms;
        logic           pressed;
        logic [ChW-1:0] channel;
        logic           last;
    } out_item_t;

    // Operands for the shared compare unit: lhs >= rhs, signed
    typedef struct packed {
        logic signed [CmpW-1:0] lhs;
        logic signed [CmpW-1:0] rhs;
    } cmp_req_t;

endpackage
`default_nettype wire

@@ rtl/core/psee_cmp_unit.sv @@
// Shared signed greater-or-equal compare unit.
`default_nettype none
module psee_cmp_unit (
    input  psee_pkg::cmp_req_t req,
    output logic               ge
);

    assign ge = ($signed(req.lhs) >= $signed(req.rhs));

endmodule
`default_nettype wire

@@ rtl/core/psee_ctrl.sv @@
// Sequencer: builds the channel mask over the shared compare unit, then scans for edges.
`default_nettype none
module psee_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [psee_pkg::TrigThrW-1:0]       trig_thr,
    input  logic [psee_pkg::StickThrW-1:0]      stick_thr,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  psee_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output psee_pkg::out_item_t                 out_data,
    output psee_pkg::cmp_req_t                  cmp_req,
    input  logic                                cmp_ge
);

    localparam int CmpW = psee_pkg::CmpW;

    psee_pkg::state_t                     state_reg, state_next;
    logic [psee_pkg::StepW-1:0]           step_reg, step_next;
    logic [psee_pkg::ChW-1:0]             ch_reg, ch_next;
    logic [psee_pkg::NumChannels-1:0]     mask_reg, mask_next;
    logic [psee_pkg::NumChannels-1:0]     prev_reg, prev_next;
    logic [psee_pkg::NumChannels-1:0]     changed_reg, changed_next;
    psee_pkg::in_item_t                   sample_reg, sample_next;
    logic                                 out_valid_reg, out_valid_next;
    psee_pkg::out_item_t                  out_reg, out_next;

    logic                                 slot_free;
    logic                                 load;
    logic [psee_pkg::NumChannels-1:0]     ch_bit;
    logic [psee_pkg::NumChannels-1:0]     changed_left;
    logic [psee_pkg::ChW-1:0]             cmp_ch;
    logic signed [psee_pkg::CmpW-1:0]     thr_pos;
    logic signed [psee_pkg::CmpW-1:0]     thr_neg;
    logic signed [psee_pkg::CmpW-1:0]     axis;

    assign slot_free    = !out_valid_reg || !out_stall;
    assign ch_bit       = psee_pkg::NumChannels'(1) << ch_reg;
    assign changed_left = changed_reg & ~ch_bit;
    assign thr_pos      = {2'b00, stick_thr};
    assign thr_neg      = -thr_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psee_pkg::ST_IDLE;
            step_reg      <= '0;
            ch_reg        <= '0;
            prev_reg      <= '0;
            changed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ch_reg        <= ch_next;
            prev_reg      <= prev_next;
            changed_reg   <= changed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg   <= mask_next;
        sample_reg <= sample_next;
        out_reg    <= out_next;
    end

    // Operand selection for the current compare step
    always_comb
    begin
        axis        = '0;
        cmp_req.lhs = '0;
        cmp_req.rhs = '0;
        cmp_ch      = psee_pkg::ChLt;
        case (step_reg)
            4'd2, 4'd3: axis = CmpW'($signed(sample_reg.left_y));
            4'd4, 4'd5: axis = CmpW'($signed(sample_reg.left_x));
            4'd6, 4'd7: axis = CmpW'($signed(sample_reg.right_y));
            4'd8, 4'd9: axis = CmpW'($signed(sample_reg.right_x));
            default:    axis = '0;
        endcase
        case (step_reg)
            4'd0:
            begin
                cmp_req.lhs = {9'd0, sample_reg.trig_l};
                cmp_req.rhs = {9'd0, trig_thr};
                cmp_ch      = psee_pkg::ChLt;
            end
            4'd1:
            begin
                cmp_req.lhs = {9'd0, sample_reg.trig_r};
                cmp_req.rhs = {9'd0, trig_thr};
                cmp_ch      = psee_pkg::ChRt;
            end
            default:
            begin
                // Even steps test the positive direction, odd steps the negative
                if (step_reg[0] == 1'b0)
                begin
                    cmp_req.lhs = axis;
                    cmp_req.rhs = thr_pos;
                end
                else
                begin
                    cmp_req.lhs = thr_neg;
                    cmp_req.rhs = axis;
                end
                case (step_reg)
                    4'd2:    cmp_ch = psee_pkg::ChLsUp;
                    4'd3:    cmp_ch = psee_pkg::ChLsDown;
                    4'd4:    cmp_ch = psee_pkg::ChLsRight;
                    4'd5:    cmp_ch = psee_pkg::ChLsLeft;
                    4'd6:    cmp_ch = psee_pkg::ChRsUp;
                    4'd7:    cmp_ch = psee_pkg::ChRsDown;
                    4'd8:    cmp_ch = psee_pkg::ChRsRight;
                    default: cmp_ch = psee_pkg::ChRsLeft;
                endcase
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        ch_next      = ch_reg;
        mask_next    = mask_reg;
        prev_next    = prev_reg;
        changed_next = changed_reg;
        sample_next  = sample_reg;
        out_next     = out_reg;
        load         = 1'b0;

        case (state_reg)
            psee_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = in_data;
                    // Drop the unnamed bit 11; A..Y move down to 11..14
                    mask_next   = {10'd0, in_data.buttons[15:12], in_data.buttons[10:0]};
                    step_next   = '0;
                    state_next  = psee_pkg::ST_CMP;
                end
            end
            psee_pkg::ST_CMP:
            begin
                mask_next = mask_reg
                          | (psee_pkg::NumChannels'(cmp_ge) << cmp_ch);
                if (step_reg == psee_pkg::StepW'(psee_pkg::CmpSteps - 1))
                begin
                    changed_next = mask_next ^ prev_reg;
                    prev_next    = mask_next;
                    ch_next      = '0;
                    state_next   = psee_pkg::ST_SCAN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            psee_pkg::ST_SCAN:
            begin
                if (changed_reg == '0)
                begin
                    state_next = psee_pkg::ST_IDLE;
                end
                else if (changed_reg[ch_reg])
                begin
                    // Hold on this channel until the output slot frees up
                    if (slot_free)
                    begin
                        load                   = 1'b1;
                        out_next.event_time_ms = sample_reg.time_ms;
                        out_next.pressed       = mask_reg[ch_reg];
                        out_next.channel       = ch_reg;
                        out_next.last          = (changed_left == '0);
                        changed_next           = changed_left;
                        if (ch_reg != psee_pkg::ChLastIdx)
                        begin
                            ch_next = ch_reg + 1'b1;
                        end
                    end
                end
                else if (ch_reg != psee_pkg::ChLastIdx)
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = psee_pkg::ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_stall  = (state_reg != psee_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == psee_pkg::ST_CMP && step_reg == '0))
        else $error("accepted transaction did not start the compare sequence");

    a_scan_mask_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psee_pkg::ST_SCAN) |-> (prev_reg == mask_reg))
        else $error("previous mask not updated before scan");

    a_one_edge_per_load: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> ($countones(changed_reg) == $countones($past(changed_reg)) - 1))
        else $error("emitted transaction did not retire exactly one changed channel");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psee_pkg::ST_CMP) |->
            (step_reg <= psee_pkg::StepW'(psee_pkg::CmpSteps - 1)))
        else $error("compare step counter out of range");
`endif

endmodule
`default_nettype wire

@@ rtl/core/pad_state_edge_event_encoder.sv @@
// Top level of the gamepad edge-event encoder: threshold registers and core wiring.
// Path: a sample accepted into the sample register walks the 10 compare steps, then the scan up
//   to the first changed channel loads its first event into the output register.
// Samples: a new sample is taken only once the previous one has finished its compare steps and
//   its scan, set by the single shared comparator and the one-channel-per-cycle scan (while the output is free).
// Reset (rst_n, async low): thresholds to 64 and 16384, previous mask to all released.
`default_nettype none
module pad_state_edge_event_encoder (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [psee_pkg::CfgIndexW-1:0]     cfg_index,
    input  logic [psee_pkg::CfgDataW-1:0]      cfg_data,
    // Sample channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  psee_pkg::in_item_t                 in_data,
    // Event channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output psee_pkg::out_item_t                out_data
);

    logic [psee_pkg::TrigThrW-1:0]  trig_thr_reg, trig_thr_next;
    logic [psee_pkg::StickThrW-1:0] stick_thr_reg, stick_thr_next;

    psee_pkg::cmp_req_t cmp_req;
    logic               cmp_ge;

    // Threshold registers; write them only while no sample is in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_thr_reg  <= psee_pkg::TrigThrReset;
            stick_thr_reg <= psee_pkg::StickThrReset;
        end
        else
        begin
            trig_thr_reg  <= trig_thr_next;
            stick_thr_reg <= stick_thr_next;
        end
    end

    always_comb
    begin
        trig_thr_next  = trig_thr_reg;
        stick_thr_next = stick_thr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                psee_pkg::RegTrigThr:  trig_thr_next  = cfg_data[psee_pkg::TrigThrW-1:0];
                psee_pkg::RegStickThr: stick_thr_next = cfg_data[psee_pkg::StickThrW-1:0];
                default:               ;
            endcase
        end
    end

    // Sequencer: loads the sample, walks the compare steps, then scans for edges
    psee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .trig_thr  (trig_thr_reg),
        .stick_thr (stick_thr_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmp_req   (cmp_req),
        .cmp_ge    (cmp_ge)
    );

    // Single comparator shared by all trigger and stick direction tests
    psee_cmp_unit u_cmp (
        .req (cmp_req),
        .ge  (cmp_ge)
    );

endmodule
`default_nettype wire

@@ verif/tb_pad_state_edge_event_encoder.sv @@
// Self-checking testbench for the gamepad edge-event encoder: directed table plus random samples.
`timescale 1ns / 1ps
module tb_pad_state_edge_event_encoder;

    // After the last expected event a sample with no change may still be in
    // the compare steps and the scan: the 10 compare steps, the scan over the
    // 25 channels and the output register, plus margin.
    localparam int SettleCycles = 48;
    localparam int MaxWait      = 19;
    localparam int NumDirected  = 25;
    localparam int NumPhases    = 6;
    localparam int PhaseItems   = 42;
    localparam psee_pkg::out_item_t NoEvent = '0;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    // One row of the directed table. typed_n < 0 leaves the expectation to
    // the predictor; 0 or 1 gives the events written in the row.
    typedef struct packed {
        row_kind_t                          kind;
        logic [psee_pkg::CfgIndexW-1:0]     reg_sel;
        logic [psee_pkg::CfgDataW-1:0]      reg_val;
        psee_pkg::in_item_t                 smp;
        int                                 typed_n;
        psee_pkg::out_item_t                typed_ev;
    } dir_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [psee_pkg::CfgIndexW-1:0]     cfg_index;
    logic [psee_pkg::CfgDataW-1:0]      cfg_data;
    logic                               in_valid;
    logic                               in_stall;
    psee_pkg::in_item_t                 in_data;
    logic                               out_valid;
    logic                               out_stall;
    psee_pkg::out_item_t                out_data;

    // Predictor state: thresholds and the channel mask of the last sample
    logic [psee_pkg::TrigThrW-1:0]      trig_thr_q;
    logic [psee_pkg::StickThrW-1:0]     stick_thr_q;
    logic [psee_pkg::NumChannels-1:0]   held_mask;

    // Events still owed by the block, oldest first
    psee_pkg::out_item_t                pending_events[$];

    dir_row_t                           dir_rows [NumDirected];
    psee_pkg::in_item_t                 last_smp;
    bit                                 no_gaps;
    int                                 mismatches;
    int                                 n_samples;
    int                                 n_events;
    int                                 n_presses;
    int                                 n_writes;
    logic [psee_pkg::NumChannels-1:0]   seen_press;
    logic [psee_pkg::NumChannels-1:0]   seen_release;

    pad_state_edge_event_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Hard stop in case the block hangs or loses an event
    initial
    begin
        #20_000_000;
        $display("Timed out with %0d events still pending", pending_events.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Return {positive direction, negative direction} for one stick axis.
    function automatic logic [1:0] axis_dirs(logic signed [15:0] axis);
        logic signed [16:0] ax;
        logic signed [16:0] lim;
        ax  = axis;
        lim = $signed({2'b00, stick_thr_q});
        axis_dirs = {ax >= lim, ax <= -lim};
    endfunction

    function automatic logic [psee_pkg::NumChannels-1:0] pad_mask(psee_pkg::in_item_t s);
        logic [psee_pkg::NumChannels-1:0] m;
        m = '0;
        // Named buttons only: bit 11 of the button word has no channel
        m[10:0]            = s.buttons[10:0];
        m[14:11]           = s.buttons[15:12];
        m[psee_pkg::ChLt]  = s.trig_l >= trig_thr_q;
        m[psee_pkg::ChRt]  = s.trig_r >= trig_thr_q;
        {m[psee_pkg::ChLsUp], m[psee_pkg::ChLsDown]}    = axis_dirs(s.left_y);
        {m[psee_pkg::ChLsRight], m[psee_pkg::ChLsLeft]} = axis_dirs(s.left_x);
        {m[psee_pkg::ChRsUp], m[psee_pkg::ChRsDown]}    = axis_dirs(s.right_y);
        {m[psee_pkg::ChRsRight], m[psee_pkg::ChRsLeft]} = axis_dirs(s.right_x);
        return m;
    endfunction

    // Work out the edge events of one sample, in channel order, and advance
    // the held mask. Queue them only when the row gives no typed answer.
    task automatic predict_events(input psee_pkg::in_item_t s, input bit queue_them);
        logic [psee_pkg::NumChannels-1:0] now_mask;
        logic [psee_pkg::NumChannels-1:0] diff;
        psee_pkg::out_item_t              ev;
        int                               ch;
        now_mask = pad_mask(s);
        diff     = now_mask ^ held_mask;
        for (ch = 0; ch < psee_pkg::NumChannels; ch++)
        begin
            if (diff[ch])
            begin
                diff[ch]         = 1'b0;
                ev.event_time_ms = s.time_ms;
                ev.pressed       = now_mask[ch];
                ev.channel       = psee_pkg::ChW'(ch);
                ev.last          = (diff == '0);
                if (queue_them)
                    pending_events.insert(pending_events.size(), ev);
            end
        end
        held_mask = now_mask;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, MaxWait);
    endfunction

    function automatic psee_pkg::in_item_t pad(int unsigned t, int unsigned btn, int lt,
                                               int rt, int lx, int ly, int rx, int ry);
        psee_pkg::in_item_t s;
        s.time_ms = t;
        s.buttons = 16'(btn);
        s.trig_l  = 8'(lt);
        s.trig_r  = 8'(rt);
        s.left_x  = 16'(lx);
        s.left_y  = 16'(ly);
        s.right_x = 16'(rx);
        s.right_y = 16'(ry);
        return s;
    endfunction

    // Favor values on and next to the current threshold, plus the rails.
    function automatic logic [7:0] pick_trigger();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return trig_thr_q;
            3:       return trig_thr_q - 8'd1;
            4:       return trig_thr_q + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_axis();
        int t;
        t = stick_thr_q;
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'(t);
            3:       return 16'(-t);
            4:       return 16'(t - 1);
            5:       return 16'(1 - t);
            6:       return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Next random sample: mostly a small step from the previous one so that
    // a sample flips a few channels, sometimes a wholesale change, and now
    // and then the same pad state again.
    function automatic psee_pkg::in_item_t next_sample(psee_pkg::in_item_t prev);
        psee_pkg::in_item_t s;
        int unsigned        roll;
        s = prev;
        s.time_ms = prev.time_ms + 32'($urandom_range(1, 50));
        if ($urandom_range(0, 15) == 0)
            s.time_ms = $urandom;
        roll = $urandom_range(0, 11);
        if (roll == 0)
            return s;
        if (roll < 7)
            s.buttons = prev.buttons ^ (16'h0001 << $urandom_range(0, 15));
        else if (roll < 9)
            s.buttons = 16'($urandom);
        if ($urandom_range(0, 2) == 0) s.trig_l  = pick_trigger();
        if ($urandom_range(0, 2) == 0) s.trig_r  = pick_trigger();
        if ($urandom_range(0, 2) == 0) s.left_x  = pick_axis();
        if ($urandom_range(0, 2) == 0) s.left_y  = pick_axis();
        if ($urandom_range(0, 2) == 0) s.right_x = pick_axis();
        if ($urandom_range(0, 2) == 0) s.right_y = pick_axis();
        return s;
    endfunction

    // Drop valid and hold off until every owed event is out and the block
    // has had time to finish a sample that changes nothing.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [psee_pkg::CfgIndexW-1:0] sel,
                             input logic [psee_pkg::CfgDataW-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        if (sel == psee_pkg::RegTrigThr)
            trig_thr_q = val[psee_pkg::TrigThrW-1:0];
        else if (sel == psee_pkg::RegStickThr)
            stick_thr_q = val[psee_pkg::StickThrW-1:0];
        n_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Present one sample after a random gap and hold it until accepted.
    task automatic send_sample(input psee_pkg::in_item_t s, input int typed_n,
                               input psee_pkg::out_item_t typed_ev);
        int gap;
        gap = draw_wait();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Transaction accepted at this edge
        if (typed_n < 0)
            predict_events(s, 1'b1);
        else
        begin
            predict_events(s, 1'b0);
            if (typed_n == 1)
                pending_events.insert(pending_events.size(), typed_ev);
        end
        last_smp = s;
        n_samples++;
    endtask

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Event side: random stall, compare each accepted transaction
    // ------------------------------------------------------------------
    initial
    begin
        int                  hold;
        psee_pkg::out_item_t want;
        out_stall = 1'b0;
        hold      = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                n_events++;
                if (out_data.pressed)
                begin
                    n_presses++;
                    seen_press[out_data.channel] = 1'b1;
                end
                else
                    seen_release[out_data.channel] = 1'b1;
                if (pending_events.size() == 0)
                    flag_error($sformatf("unexpected event t=%0d pressed=%0b ch=%0d last=%0b",
                        out_data.event_time_ms, out_data.pressed, out_data.channel,
                        out_data.last));
                else
                begin
                    want = pending_events.pop_front();
                    if (out_data.event_time_ms !== want.event_time_ms
                        || out_data.pressed !== want.pressed
                        || out_data.channel !== want.channel
                        || out_data.last !== want.last)
                        flag_error($sformatf(
                            "event exp t=%0d p=%0b ch=%0d last=%0b, got t=%0d p=%0b ch=%0d last=%0b",
                            want.event_time_ms, want.pressed, want.channel, want.last,
                            out_data.event_time_ms, out_data.pressed, out_data.channel,
                            out_data.last));
                end
                hold = draw_wait();
            end
            @(negedge clk);
            out_stall <= (hold != 0);
            if (hold != 0)
                hold--;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          i;
        int          p;
        int          k;
        logic [7:0]  phase_trig [NumPhases];
        logic [14:0] phase_stick [NumPhases];

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = psee_pkg::RegTrigThr;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        no_gaps      = 1'b0;
        mismatches   = 0;
        n_samples    = 0;
        n_events     = 0;
        n_presses    = 0;
        n_writes     = 0;
        seen_press   = '0;
        seen_release = '0;
        trig_thr_q   = psee_pkg::TrigThrReset;
        stick_thr_q  = psee_pkg::StickThrReset;
        held_mask    = '0;
        last_smp     = '0;

        // Directed table, walked in order from reset values
        dir_rows = '{
            // Idle pad right after reset: nothing changes
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(0, 0, 0, 0, 0, 0, 0, 0), 0,
                NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(10, 16'h0001, 0, 0, 0, 0, 0, 0), 1,
                '{32'd10, 1'b1, 5'd0, 1'b1}},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(20, 0, 0, 0, 0, 0, 0, 0), 1,
                '{32'd20, 1'b0, 5'd0, 1'b1}},
            // Unnamed button bit alone never emits
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(30, 16'h0800, 0, 0, 0, 0, 0, 0), 0,
                NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(40, 16'hF800, 0, 0, 0, 0, 0, 0), -1,
                NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0,
                pad(32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0), -1, NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(50, 0, 0, 0, 0, 0, 0, 0), -1,
                NoEvent},
            // Left trigger around the reset threshold of 64
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(60, 0, 255, 0, 0, 0, 0, 0), 1,
                '{32'd60, 1'b1, 5'd15, 1'b1}},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(70, 0, 63, 0, 0, 0, 0, 0), 1,
                '{32'd70, 1'b0, 5'd15, 1'b1}},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(80, 0, 64, 0, 0, 0, 0, 0), 1,
                '{32'd80, 1'b1, 5'd15, 1'b1}},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(90, 0, 0, 255, 0, 0, 0, 0), -1,
                NoEvent},
            // Stick rails and the exact threshold
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(100, 0, 0, 0, 0, 32767, 0, 0), -1,
                NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(110, 0, 0, 0, 0, -32768, 0, 0), -1,
                NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(120, 0, 0, 0, 16384, 0, 0, 0), -1,
                NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(130, 0, 0, 0, -16384, 0, 0, 0), -1,
                NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0,
                pad(140, 0, 0, 0, 16383, 0, -16383, 16383), -1, NoEvent},
            // All buttons, both triggers and one direction per stick axis at once, then all released
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0,
                pad(150, 16'hFFFF, 255, 255, 32767, -32768, -32768, 32767), -1, NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(160, 0, 0, 0, 0, 0, 0, 0), -1,
                NoEvent},
            // Zero thresholds: triggers always on, centered axes hit both ways.
            // Upper data bits on the trigger write must be dropped.
            '{ROW_WRITE, psee_pkg::RegTrigThr, 15'h7F00, '0, 0, NoEvent},
            '{ROW_WRITE, psee_pkg::RegStickThr, 15'd0, '0, 0, NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(170, 0, 0, 0, 0, 0, 0, 0), -1,
                NoEvent},
            // Top thresholds
            '{ROW_WRITE, psee_pkg::RegTrigThr, 15'h00FF, '0, 0, NoEvent},
            '{ROW_WRITE, psee_pkg::RegStickThr, 15'h7FFF, '0, 0, NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0,
                pad(180, 0, 255, 254, -32768, 32767, -32767, 32766), -1, NoEvent},
            '{ROW_SAMPLE, psee_pkg::RegTrigThr, 15'd0, pad(190, 0, 0, 0, 0, 0, 0, 0), -1,
                NoEvent}
        };

        // Hold reset, then release it on a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < NumDirected; i++)
        begin
            if (dir_rows[i].kind == ROW_WRITE)
                cfg_write(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            else
                send_sample(dir_rows[i].smp, dir_rows[i].typed_n, dir_rows[i].typed_ev);
        end

        // Random phases, each under its own pair of thresholds
        phase_trig  = '{8'd0, 8'd255, 8'($urandom), 8'd1, 8'd128, 8'($urandom)};
        phase_stick = '{15'd0, 15'h7FFF, 15'($urandom), 15'd1, 15'd8192, 15'($urandom)};
        for (p = 0; p < NumPhases; p++)
        begin
            cfg_write(psee_pkg::RegTrigThr, {7'($urandom), phase_trig[p]});
            cfg_write(psee_pkg::RegStickThr, phase_stick[p]);
            // Run phases 1 and 3 with no idle gaps on the sample or event side
            no_gaps = (p == 1 || p == 3);
            for (k = 0; k < PhaseItems; k++)
            begin
                // Pause the sample stream mid-phase until the event side catches up
                if (p == 2 && k == PhaseItems / 2)
                    drain();
                send_sample(next_sample(last_smp), -1, NoEvent);
            end
        end
        no_gaps = 1'b0;

        drain();
        $display("Sent %0d samples and %0d register writes; checked %0d events (%0d presses)",
            n_samples, n_writes, n_events, n_presses);
        $display("Channels seen pressed: %0d of %0d, released: %0d of %0d",
            $countones(seen_press), psee_pkg::NumChannels, $countones(seen_release),
            psee_pkg::NumChannels);
        if (mismatches == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
